// File: sv/scheme_literal_lexer_unit_defines.svh
// Assertion macros shared by the scheme literal lexer modules.
// Each macro expects clk and rst in scope at the point of use.
`ifndef SCHEME_LITERAL_LEXER_UNIT_DEFINES_SVH
`define SCHEME_LITERAL_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SLX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define SLX_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// File: sv/slx_pkg.sv
// Package for the scheme literal lexer: item types, lexer modes, kind and error codes.
// No dependencies.
`timescale 1ns / 1ps

package slx_pkg;

  // Defaults for the top-level parameters
  localparam int STRING_MAX_DEF = 1024;
  localparam int FRAC_MAX_DEF   = 9;

  // Result bundles held between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [2:0] KIND_BOOL      = 3'd0;
  localparam logic [2:0] KIND_CHAR      = 3'd1;
  localparam logic [2:0] KIND_INT       = 3'd2;
  localparam logic [2:0] KIND_DECIMAL   = 3'd3;
  localparam logic [2:0] KIND_STR_CHAR  = 3'd4;
  localparam logic [2:0] KIND_STR_END   = 3'd5;
  localparam logic [2:0] KIND_EMPTY     = 3'd6;
  localparam logic [2:0] KIND_ERROR     = 3'd7;

  // Error codes
  localparam logic [3:0] ERR_BAD_HASH      = 4'd0;
  localparam logic [3:0] ERR_MISSING_QUOTE = 4'd1;
  localparam logic [3:0] ERR_CHAR_NO_DELIM = 4'd2;
  localparam logic [3:0] ERR_INCOMPLETE    = 4'd3;
  localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
  localparam logic [3:0] ERR_NUM_NO_DELIM  = 4'd5;
  localparam logic [3:0] ERR_UNTERMINATED  = 4'd6;
  localparam logic [3:0] ERR_TOO_LONG      = 4'd7;
  localparam logic [3:0] ERR_EXPECT_PAREN  = 4'd8;
  localparam logic [3:0] ERR_BAD_INPUT     = 4'd9;
  localparam logic [3:0] ERR_OVERFLOW      = 4'd10;

  // Lexer modes, one-hot
  typedef enum logic [13:0] {
    MODE_IDLE          = 14'b00000000000001,
    MODE_COMMENT       = 14'b00000000000010,
    MODE_HASH          = 14'b00000000000100,
    MODE_CH_OPEN       = 14'b00000000001000,
    MODE_CH_ESC        = 14'b00000000010000,
    MODE_CH_CLOSE      = 14'b00000000100000,
    MODE_CH_DELIM      = 14'b00000001000000,
    MODE_MINUS         = 14'b00000010000000,
    MODE_INT           = 14'b00000100000000,
    MODE_FRAC          = 14'b00001000000000,
    MODE_STR           = 14'b00010000000000,
    MODE_STR_ESC       = 14'b00100000000000,
    MODE_PAREN         = 14'b01000000000000,
    MODE_PAREN_COMMENT = 14'b10000000000000
  } lex_mode_t;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] mantissa;
    logic [3:0]         frac_digits;
    logic [7:0]         char_value;
    logic [3:0]         err_code;
    logic               last_of_item;
  } out_item_t;

  // Results of one input item: one or two
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } bundle_t;

  // Queue write from the front
  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } queue_wr_t;

endpackage

// File: sv/slx_front.sv
// Lexer front: accepts input items, runs the token state machine, writes result bundles.
// Depends on slx_pkg and scheme_literal_lexer_unit_defines.svh.
`timescale 1ns / 1ps
`include "scheme_literal_lexer_unit_defines.svh"

module slx_front #(
  parameter int STRING_MAX = slx_pkg::STRING_MAX_DEF,
  parameter int FRAC_MAX   = slx_pkg::FRAC_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  slx_pkg::in_item_t  item,
  input  logic               queue_full,
  output slx_pkg::queue_wr_t queue_wr
);

  localparam int LEN_W = $clog2(STRING_MAX);
  localparam logic [LEN_W:0] STR_LIMIT = (LEN_W + 1)'(STRING_MAX);
  localparam logic [3:0]     FRAC_LIMIT = 4'(FRAC_MAX);

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_POINT  = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [35:0] LIMIT_POS = 36'h07fffffff;
  localparam logic [35:0] LIMIT_NEG = 36'h080000000;

  function automatic slx_pkg::out_item_t make_res(logic [2:0] kind, logic [31:0] mant,
                                                  logic [3:0] frac, logic [7:0] ch,
                                                  logic [3:0] err);
    slx_pkg::out_item_t r;
    r.kind         = kind;
    r.mantissa     = mant;
    r.frac_digits  = frac;
    r.char_value   = ch;
    r.err_code     = err;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  slx_pkg::lex_mode_t mode, mode_next;
  logic               negative, negative_next;
  logic [31:0]        accum, accum_next;
  logic [3:0]         frac_count, frac_count_next;
  logic [LEN_W-1:0]   string_length, string_length_next;
  logic [7:0]         held_char, held_char_next;

  logic [7:0]  b;
  logic        e;
  logic        accept;
  logic        is_sp, is_dg, is_dl;
  logic [3:0]  dval;
  logic [35:0] acc_wide, dig_val;
  logic        dig_ok;
  logic [31:0] signed_acc;
  logic        str_ok;
  logic [7:0]  esc_char;

  // Idle decode of the current byte
  slx_pkg::lex_mode_t id_mode;
  logic               id_fail, id_digit, id_str;

  logic               use_idle;
  logic [1:0]         n_res;
  slx_pkg::out_item_t res0, res1;

  assign b      = item.in_byte;
  assign e      = item.end_mark;
  assign accept = item_valid && !queue_full;

  // Byte classes
  assign is_sp = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_dg = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_dl = e || is_sp || b == CH_LPAR || b == CH_RPAR || b == CH_DQUOTE || b == CH_SEMI;
  assign dval  = b[3:0];

  // Next magnitude: accum * 10 + digit, checked against the signed limit
  assign acc_wide   = {4'b0000, accum};
  assign dig_val    = (acc_wide << 3) + (acc_wide << 1) + {32'd0, dval};
  assign dig_ok     = dig_val <= (negative ? LIMIT_NEG : LIMIT_POS);
  assign signed_acc = negative ? (32'd0 - accum) : accum;

  assign str_ok   = ({1'b0, string_length} + (LEN_W + 1)'(1)) < STR_LIMIT;
  assign esc_char = (b == CH_N) ? CH_NL : b;

  // What an idle lexer does with this byte
  always_comb begin
    id_mode  = slx_pkg::MODE_IDLE;
    id_fail  = 1'b0;
    id_digit = 1'b0;
    id_str   = 1'b0;
    if (e || is_sp) begin
      id_mode = slx_pkg::MODE_IDLE;
    end else if (b == CH_SEMI) begin
      id_mode = slx_pkg::MODE_COMMENT;
    end else if (b == CH_HASH) begin
      id_mode = slx_pkg::MODE_HASH;
    end else if (is_dg) begin
      id_mode  = slx_pkg::MODE_INT;
      id_digit = 1'b1;
    end else if (b == CH_MINUS) begin
      id_mode = slx_pkg::MODE_MINUS;
    end else if (b == CH_DQUOTE) begin
      id_mode = slx_pkg::MODE_STR;
      id_str  = 1'b1;
    end else if (b == CH_LPAR) begin
      id_mode = slx_pkg::MODE_PAREN;
    end else begin
      id_fail = 1'b1;
    end
  end

  // Token state machine
  always_comb begin
    mode_next          = mode;
    negative_next      = negative;
    accum_next         = accum;
    frac_count_next    = frac_count;
    string_length_next = string_length;
    held_char_next     = held_char;
    use_idle           = 1'b0;
    n_res              = 2'd0;
    res0               = make_res(slx_pkg::KIND_BOOL, 32'd0, 4'd0, 8'd0, 4'd0);
    res1               = make_res(slx_pkg::KIND_BOOL, 32'd0, 4'd0, 8'd0, 4'd0);

    case (mode)
      slx_pkg::MODE_COMMENT: begin
        if (e || b == CH_NL) mode_next = slx_pkg::MODE_IDLE;
      end
      slx_pkg::MODE_HASH: begin
        if (!e && b == CH_T) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0      = make_res(slx_pkg::KIND_BOOL, 32'd0, 4'd0, 8'd1, 4'd0);
          n_res     = 2'd1;
        end else if (!e && b == CH_F) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0      = make_res(slx_pkg::KIND_BOOL, 32'd0, 4'd0, 8'd0, 4'd0);
          n_res     = 2'd1;
        end else if (!e && b == CH_QUOTE) begin
          mode_next = slx_pkg::MODE_CH_OPEN;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0      = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_BAD_HASH);
          n_res     = 2'd1;
        end
      end
      slx_pkg::MODE_CH_OPEN: begin
        if (e) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_INCOMPLETE);
          n_res = 2'd1;
        end else if (b == CH_BSLASH) begin
          mode_next = slx_pkg::MODE_CH_ESC;
        end else begin
          held_char_next = b;
          mode_next      = slx_pkg::MODE_CH_CLOSE;
        end
      end
      slx_pkg::MODE_CH_ESC: begin
        if (!e && b == CH_N) begin
          held_char_next = CH_NL;
          mode_next      = slx_pkg::MODE_CH_CLOSE;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_BAD_ESCAPE);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_CH_CLOSE: begin
        if (!e && b == CH_QUOTE) begin
          mode_next = slx_pkg::MODE_CH_DELIM;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_MISSING_QUOTE);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_CH_DELIM: begin
        if (is_dl) begin
          res0     = make_res(slx_pkg::KIND_CHAR, 32'd0, 4'd0, held_char, 4'd0);
          n_res    = 2'd1;
          use_idle = 1'b1;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_CHAR_NO_DELIM);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_MINUS: begin
        if (!e && is_dg) begin
          negative_next   = 1'b1;
          accum_next      = {28'd0, dval};
          frac_count_next = 4'd0;
          mode_next       = slx_pkg::MODE_INT;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_BAD_INPUT);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_INT: begin
        if (!e && is_dg) begin
          if (dig_ok) begin
            accum_next = dig_val[31:0];
          end else begin
            mode_next = slx_pkg::MODE_IDLE;
            res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_OVERFLOW);
            n_res = 2'd1;
          end
        end else if (!e && b == CH_POINT) begin
          frac_count_next = 4'd0;
          mode_next       = slx_pkg::MODE_FRAC;
        end else if (is_dl) begin
          res0     = make_res(slx_pkg::KIND_INT, signed_acc, 4'd0, 8'd0, 4'd0);
          n_res    = 2'd1;
          use_idle = 1'b1;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_NUM_NO_DELIM);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_FRAC: begin
        if (!e && is_dg) begin
          // digits past the fraction limit are dropped
          if (frac_count < FRAC_LIMIT) begin
            if (dig_ok) begin
              accum_next      = dig_val[31:0];
              frac_count_next = frac_count + 4'd1;
            end else begin
              mode_next = slx_pkg::MODE_IDLE;
              res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_OVERFLOW);
              n_res = 2'd1;
            end
          end
        end else if (is_dl) begin
          res0     = make_res(slx_pkg::KIND_DECIMAL, signed_acc, frac_count, 8'd0, 4'd0);
          n_res    = 2'd1;
          use_idle = 1'b1;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_NUM_NO_DELIM);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_STR, slx_pkg::MODE_STR_ESC: begin
        if (e) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_UNTERMINATED);
          n_res = 2'd1;
        end else if (mode == slx_pkg::MODE_STR && b == CH_DQUOTE) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0      = make_res(slx_pkg::KIND_STR_END, 32'd0, 4'd0, 8'd0, 4'd0);
          n_res     = 2'd1;
        end else if (mode == slx_pkg::MODE_STR && b == CH_BSLASH) begin
          mode_next = slx_pkg::MODE_STR_ESC;
        end else if (!str_ok) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_TOO_LONG);
          n_res = 2'd1;
        end else begin
          string_length_next = string_length + LEN_W'(1);
          mode_next          = slx_pkg::MODE_STR;
          res0 = make_res(slx_pkg::KIND_STR_CHAR, 32'd0, 4'd0,
                          (mode == slx_pkg::MODE_STR_ESC) ? esc_char : b, 4'd0);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_PAREN: begin
        if (!e && is_sp) begin
          mode_next = slx_pkg::MODE_PAREN;
        end else if (!e && b == CH_SEMI) begin
          mode_next = slx_pkg::MODE_PAREN_COMMENT;
        end else if (!e && b == CH_RPAR) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0      = make_res(slx_pkg::KIND_EMPTY, 32'd0, 4'd0, 8'd0, 4'd0);
          n_res     = 2'd1;
        end else begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_EXPECT_PAREN);
          n_res = 2'd1;
        end
      end
      slx_pkg::MODE_PAREN_COMMENT: begin
        if (e) begin
          mode_next = slx_pkg::MODE_IDLE;
          res0 = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_EXPECT_PAREN);
          n_res = 2'd1;
        end else if (b == CH_NL) begin
          mode_next = slx_pkg::MODE_PAREN;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    // Delimiter after a token, or a plain idle byte, starts the next token
    if (use_idle) begin
      mode_next = id_mode;
      if (id_digit) begin
        negative_next   = 1'b0;
        accum_next      = {28'd0, dval};
        frac_count_next = 4'd0;
      end
      if (id_str) string_length_next = '0;
      if (id_fail) begin
        if (n_res == 2'd0) begin
          res0  = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_BAD_INPUT);
          n_res = 2'd1;
        end else begin
          res1  = make_res(slx_pkg::KIND_ERROR, 32'd0, 4'd0, 8'd0, slx_pkg::ERR_BAD_INPUT);
          n_res = 2'd2;
        end
      end
    end

    // Mark the final result of the item
    if (n_res == 2'd1) res0.last_of_item = 1'b1;
    if (n_res == 2'd2) res1.last_of_item = 1'b1;
  end

  // Bundle to the queue
  always_comb begin
    queue_wr.push          = accept && (n_res != 2'd0);
    queue_wr.bundle.two    = (n_res == 2'd2);
    queue_wr.bundle.first  = res0;
    queue_wr.bundle.second = res1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= slx_pkg::MODE_IDLE;
      negative      <= 1'b0;
      accum         <= 32'd0;
      frac_count    <= 4'd0;
      string_length <= '0;
      held_char     <= 8'd0;
    end else if (accept) begin
      mode          <= mode_next;
      negative      <= negative_next;
      accum         <= accum_next;
      frac_count    <= frac_count_next;
      string_length <= string_length_next;
      held_char     <= held_char_next;
    end
  end

  // A second result is only ever the error after a finished token
  `SLX_ASSERT(a_second_is_error, (queue_wr.push && queue_wr.bundle.two) |-> (queue_wr.bundle.second.kind == slx_pkg::KIND_ERROR), "second result of an item is not an error")
  // A positive magnitude never reaches bit 31
  `SLX_ASSERT(a_pos_magnitude, ((mode == slx_pkg::MODE_INT || mode == slx_pkg::MODE_FRAC) && !negative) |-> !accum[31], "positive magnitude above limit")

endmodule

// File: sv/slx_back.sv
// Lexer back: bundle queue and result serializer toward the token channel.
// Depends on slx_pkg and scheme_literal_lexer_unit_defines.svh.
`timescale 1ns / 1ps
`include "scheme_literal_lexer_unit_defines.svh"

module slx_back (
  input  logic                clk,
  input  logic                rst,
  input  slx_pkg::queue_wr_t  queue_wr,
  output logic                queue_full,
  output logic                token_valid,
  input  logic                token_stall,
  output slx_pkg::out_item_t  token
);

  localparam int QW = $clog2(slx_pkg::QUEUE_DEPTH);
  localparam logic [QW:0] DEPTH = (QW + 1)'(slx_pkg::QUEUE_DEPTH);

  slx_pkg::bundle_t q [slx_pkg::QUEUE_DEPTH];
  logic [QW-1:0]    wr_ptr, rd_ptr;
  logic [QW:0]      count;
  logic             sub;
  slx_pkg::bundle_t head;
  logic             pop;
  logic             push;

  assign head        = q[rd_ptr];
  assign push        = queue_wr.push;
  assign queue_full  = (count == DEPTH);
  assign token_valid = (count != '0);
  assign token       = sub ? head.second : head.first;
  // Bundle leaves once its last result is taken
  assign pop = token_valid && !token_stall && (sub || !head.two);

  // Bundle storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= queue_wr.bundle;
  end

  // Pointers, fill count and result select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QW'(1);
      if (pop) rd_ptr <= rd_ptr + QW'(1);
      count <= count + (QW + 1)'(push) - (QW + 1)'(pop);
      if (pop) begin
        sub <= 1'b0;
      end else if (token_valid && !token_stall) begin
        sub <= 1'b1;
      end
    end
  end

  `SLX_ASSERT(a_no_push_full, push |-> !queue_full, "bundle written into a full queue")
  `SLX_ASSERT(a_sub_needs_two, sub |-> (token_valid && head.two), "second result selected on a one-result bundle")
  `SLX_ASSERT(a_last_matches, token_valid |-> (token.last_of_item == (sub || !head.two)), "last_of_item disagrees with bundle position")
  `SLX_ASSERT_NEXT(a_count_bound, 1'b1, count <= DEPTH, "queue count beyond depth")

endmodule

// File: sv/scheme_literal_lexer_unit.sv
// Latency: a result is offered the cycle after its item is accepted, if the queue is empty.
// Throughput: one item per cycle unless stalled; two results share the token channel in turn.
// The input side stalls only when all four bundle slots of the front/back queue are full.
// Items that cause no result (whitespace, comments, token prefixes) take no slot.
// Reset (synchronous, active high) returns the lexer to idle and empties the queue.
// Top level: lexer front, bundle queue and serializer; depends on slx_pkg, slx_front, slx_back.
`timescale 1ns / 1ps

module scheme_literal_lexer_unit #(
  parameter int STRING_MAX = slx_pkg::STRING_MAX_DEF,
  parameter int FRAC_MAX   = slx_pkg::FRAC_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  slx_pkg::in_item_t  item,
  output logic               token_valid,
  input  logic               token_stall,
  output slx_pkg::out_item_t token
);

  slx_pkg::queue_wr_t queue_wr;
  logic               queue_full;

  assign item_stall = queue_full;

  slx_front #(
    .STRING_MAX(STRING_MAX),
    .FRAC_MAX  (FRAC_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .queue_full(queue_full),
    .queue_wr  (queue_wr)
  );

  slx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_wr   (queue_wr),
    .queue_full (queue_full),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token      (token)
  );

endmodule
